[src/aabb_penetration_resolver_assert.svh]
// Assertion macros shared by the resolver modules.
`ifndef AABB_PENETRATION_RESOLVER_ASSERT_SVH
`define AABB_PENETRATION_RESOLVER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, inactive while reset is asserted
`define AABBPR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("aabbpr assertion failed");
// Checked property, also active during reset
`define AABBPR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("aabbpr assertion failed");
`else
`define AABBPR_ASSERT(lbl, clk, rst_n, prop)
`define AABBPR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[src/aabbpr_pkg.sv]
package aabbpr_pkg;

	// default sizes
	localparam int AABBPR_COORD_BITS = 20;
	localparam int AABBPR_QUEUE_DEPTH = 4;
	localparam int SIZE_BITS = 16;

	// register reset values (32 px and 48 px in 1/16 pixel)
	localparam logic [SIZE_BITS-1:0] BOX_WIDTH_RST = 16'd512;
	localparam logic [SIZE_BITS-1:0] BOX_HEIGHT_RST = 16'd768;

	// register indexes
	localparam logic REG_BOX_WIDTH = 1'b0;
	localparam logic REG_BOX_HEIGHT = 1'b1;

	// item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_WALL = 1'b1;

	// axis modes; the unused code acts as least mode
	localparam logic [1:0] MODE_LEAST = 2'd0;
	localparam logic [1:0] MODE_X = 2'd1;
	localparam logic [1:0] MODE_Y = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// control part of a queued word
	typedef struct packed {
		logic       start;
		logic       solid;
		logic       last;
		logic [1:0] mode;
	} item_ctl_t;

	localparam int CTL_W = $bits(item_ctl_t);

	// width holding coordinate sums, doubled coordinates and size offsets
	function automatic int ext_width(int coord_bits);
		return ((coord_bits > SIZE_BITS) ? coord_bits : SIZE_BITS) + 3;
	endfunction

	// queued word: ctl, then per axis: edge-minus-size, far edge/start,
	// direction threshold, saturated near target
	function automatic int item_width(int coord_bits);
		return CTL_W + 4 * ext_width(coord_bits) + 4 * coord_bits;
	endfunction

endpackage

[src/aabbpr_queue.sv]
module aabbpr_queue
	import aabbpr_pkg::*;
#(
	parameter int DATA_W = 8,
	parameter int DEPTH = AABBPR_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output logic [DATA_W-1:0] rd_data
);

`include "aabb_penetration_resolver_assert.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop, full, empty;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign wr_ready = !full;
	assign rd_valid = !empty;
	assign push = wr_valid && !full;
	assign pop = rd_ready && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`AABBPR_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`AABBPR_ASSERT(a_no_pop_empty, clk, arst_n, !(pop && empty))
	`AABBPR_ASSERT(a_count_step, clk, arst_n, (push && !pop) |=> !empty)

endmodule

[src/aabbpr_front.sv]
module aabbpr_front
	import aabbpr_pkg::*;
#(
	parameter int COORD_BITS = AABBPR_COORD_BITS,
	parameter int ITEM_W = item_width(COORD_BITS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [SIZE_BITS-1:0]         cfg_wdata,
	// input words
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic [1:0]                   axis_mode,
	input  logic signed [COORD_BITS-1:0] wall_left,
	input  logic signed [COORD_BITS-1:0] wall_top,
	input  logic signed [COORD_BITS-1:0] wall_right,
	input  logic signed [COORD_BITS-1:0] wall_bottom,
	input  logic                         solid,
	input  logic                         last_wall,
	// to queue
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic [ITEM_W-1:0]            q_item
);

	localparam int C = COORD_BITS;
	localparam int EW = ext_width(COORD_BITS);

	logic [SIZE_BITS-1:0] box_width_q, box_height_q;
	logic signed [EW-1:0] w_e, h_e, wl_e, wr_e, wt_e, wb_e;
	logic signed [EW-1:0] ax, ay, sx, sy;
	logic signed [C-1:0] bx, by, tx, ty;
	item_ctl_t ctl;
	logic [ITEM_W-1:0] item, item_s1;
	logic valid_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_width_q <= BOX_WIDTH_RST;
			box_height_q <= BOX_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_WIDTH: box_width_q <= cfg_wdata;
				REG_BOX_HEIGHT: box_height_q <= cfg_wdata;
				default: box_width_q <= box_width_q;
			endcase
		end
	end

	// widen edges and sizes
	assign w_e = {{(EW - SIZE_BITS){1'b0}}, box_width_q};
	assign h_e = {{(EW - SIZE_BITS){1'b0}}, box_height_q};
	assign wl_e = {{(EW - C){wall_left[C-1]}}, wall_left};
	assign wr_e = {{(EW - C){wall_right[C-1]}}, wall_right};
	assign wt_e = {{(EW - C){wall_top[C-1]}}, wall_top};
	assign wb_e = {{(EW - C){wall_bottom[C-1]}}, wall_bottom};

	// overlap bound and near-side target: box corner must exceed edge - size
	assign ax = wl_e - w_e;
	assign ay = wt_e - h_e;
	// push toward near side when 2*corner < near + far - size
	assign sx = wl_e + wr_e - w_e;
	assign sy = wt_e + wb_e - h_e;

	// near-side target saturates at the low end of the range
	assign tx = ((&ax[EW-1:C-1]) || !(|ax[EW-1:C-1])) ? ax[C-1:0]
		: {1'b1, {(C - 1){1'b0}}};
	assign ty = ((&ay[EW-1:C-1]) || !(|ay[EW-1:C-1])) ? ay[C-1:0]
		: {1'b1, {(C - 1){1'b0}}};

	// far edge slot carries the start position for a start word
	assign bx = (op == OP_START) ? start_x : wall_right;
	assign by = (op == OP_START) ? start_y : wall_bottom;

	// classify
	assign ctl.start = (op == OP_START);
	assign ctl.solid = solid;
	assign ctl.last = last_wall;
	assign ctl.mode = axis_mode;

	assign item = {ctl, ax, bx, sx, tx, ay, by, sy, ty};

	// input register stage
	assign in_ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

	assign q_valid = valid_s1;
	assign q_item = item_s1;

endmodule

[src/aabbpr_back.sv]
module aabbpr_back
	import aabbpr_pkg::*;
#(
	parameter int COORD_BITS = AABBPR_COORD_BITS,
	parameter int ITEM_W = item_width(COORD_BITS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// from queue
	input  logic                         q_valid,
	output logic                         q_ready,
	input  logic [ITEM_W-1:0]            q_item,
	// result words
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] box_x,
	output logic signed [COORD_BITS-1:0] box_y,
	output logic                         stopped_x,
	output logic                         stopped_y,
	output logic                         done_res
);

`include "aabb_penetration_resolver_assert.svh"

	localparam int C = COORD_BITS;
	localparam int EW = ext_width(COORD_BITS);

	item_ctl_t head_ctl;
	logic signed [EW-1:0] ax, ay, sx, sy;
	logic signed [C-1:0] bx, by, tx, ty;
	logic signed [EW-1:0] cx, cy, bx_e, by_e, pen_x, pen_y;
	logic signed [C-1:0] new_x, new_y;
	logic left_x, up_y, overlap, take_x, pop;

	logic signed [C-1:0] cur_x_q, cur_y_q;
	logic [1:0] mode_q;
	logic stop_x_q, stop_y_q, done_q, out_valid_q;

	assign {head_ctl, ax, bx, sx, tx, ay, by, sy, ty} = q_item;

	// widen running position and far edges
	assign cx = {{(EW - C){cur_x_q[C-1]}}, cur_x_q};
	assign cy = {{(EW - C){cur_y_q[C-1]}}, cur_y_q};
	assign bx_e = {{(EW - C){bx[C-1]}}, bx};
	assign by_e = {{(EW - C){by[C-1]}}, by};

	// strict overlap of a solid wall
	assign overlap = head_ctl.solid && (cx > ax) && (cx < bx_e)
		&& (cy > ay) && (cy < by_e);

	// side choice per axis; ties go to the far edge
	assign left_x = (cx <<< 1) < sx;
	assign up_y = (cy <<< 1) < sy;
	assign pen_x = left_x ? (cx - ax) : (bx_e - cx);
	assign pen_y = up_y ? (cy - ay) : (by_e - cy);
	assign new_x = left_x ? tx : bx;
	assign new_y = up_y ? ty : by;

	// axis choice; ties push vertically
	always_comb begin
		case (mode_q)
			MODE_X: take_x = 1'b1;
			MODE_Y: take_x = 1'b0;
			default: take_x = (pen_x < pen_y);
		endcase
	end

	// one word per cycle while the result slot is free or being taken
	assign q_ready = !out_valid_q || out_ready;
	assign pop = q_valid && q_ready;

	// running state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			mode_q <= MODE_LEAST;
			stop_x_q <= 1'b0;
			stop_y_q <= 1'b0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (head_ctl.start) begin
					cur_x_q <= bx;
					cur_y_q <= by;
					mode_q <= head_ctl.mode;
					stop_x_q <= 1'b0;
					stop_y_q <= 1'b0;
					done_q <= 1'b0;
				end else begin
					done_q <= head_ctl.last;
					if (overlap && take_x) begin
						cur_x_q <= new_x;
						stop_x_q <= 1'b1;
					end
					if (overlap && !take_x) begin
						cur_y_q <= new_y;
						stop_y_q <= 1'b1;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign box_x = cur_x_q;
	assign box_y = cur_y_q;
	assign stopped_x = stop_x_q;
	assign stopped_y = stop_y_q;
	assign done_res = done_q;

	`AABBPR_ASSERT(a_start_clears, clk, arst_n, (pop && head_ctl.start) |=> (out_valid_q && !stop_x_q && !stop_y_q && !done_q))
	`AABBPR_ASSERT(a_stop_x_by_wall, clk, arst_n, $rose(stop_x_q) |-> $past(pop && !head_ctl.start))
	`AABBPR_ASSERT(a_stop_y_by_wall, clk, arst_n, $rose(stop_y_q) |-> $past(pop && !head_ctl.start))

endmodule

[src/aabb_penetration_resolver.sv]
// An accepted word passes the front input register and the four-entry queue
// before the back end registers its result. While results are taken, the back
// end resolves one wall per cycle against the running position.
// Reset (arst_n low, asynchronous): position, mode and stop flags clear,
// box size returns to 512 by 768, queue and result slot empty.
module aabb_penetration_resolver
	import aabbpr_pkg::*;
#(
	parameter int COORD_BITS = AABBPR_COORD_BITS,
	parameter int QUEUE_DEPTH = AABBPR_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [SIZE_BITS-1:0]         cfg_wdata,
	// input words
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic [1:0]                   axis_mode,
	input  logic signed [COORD_BITS-1:0] wall_left,
	input  logic signed [COORD_BITS-1:0] wall_top,
	input  logic signed [COORD_BITS-1:0] wall_right,
	input  logic signed [COORD_BITS-1:0] wall_bottom,
	input  logic                         solid,
	input  logic                         last_wall,
	// result words
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] box_x,
	output logic signed [COORD_BITS-1:0] box_y,
	output logic                         stopped_x,
	output logic                         stopped_y,
	output logic                         done_res
);

	localparam int ITEM_W = item_width(COORD_BITS);

	logic f_valid, f_ready, b_valid, b_ready;
	logic [ITEM_W-1:0] f_item, b_item;

	// accept and precompute
	aabbpr_front #(
		.COORD_BITS(COORD_BITS),
		.ITEM_W(ITEM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.start_x(start_x),
		.start_y(start_y),
		.axis_mode(axis_mode),
		.wall_left(wall_left),
		.wall_top(wall_top),
		.wall_right(wall_right),
		.wall_bottom(wall_bottom),
		.solid(solid),
		.last_wall(last_wall),
		.q_valid(f_valid),
		.q_ready(f_ready),
		.q_item(f_item)
	);

	// decoupling queue
	aabbpr_queue #(
		.DATA_W(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data(f_item),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data(b_item)
	);

	// resolve against running position
	aabbpr_back #(
		.COORD_BITS(COORD_BITS),
		.ITEM_W(ITEM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(b_valid),
		.q_ready(b_ready),
		.q_item(b_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.box_x(box_x),
		.box_y(box_y),
		.stopped_x(stopped_x),
		.stopped_y(stopped_y),
		.done_res(done_res)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import aabbpr_pkg::*;

	localparam int COORD_BITS = AABBPR_COORD_BITS;
	localparam int WIDE_BITS = COORD_BITS + 4;
	localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int CHUNK_WORDS = 125;
	localparam int CHUNKS = 10;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0] wide_t;

	// one input word as offered to the block
	typedef struct {
		logic       op;
		coord_t     start_x;
		coord_t     start_y;
		logic [1:0] mode;
		coord_t     left;
		coord_t     top;
		coord_t     right;
		coord_t     bottom;
		logic       solid;
		logic       last;
	} in_word_t;

	// one corrected-position word
	typedef struct {
		coord_t x;
		coord_t y;
		logic   stop_x;
		logic   stop_y;
		logic   done;
	} pos_word_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block ports
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = REG_BOX_WIDTH;
	logic [SIZE_BITS-1:0] cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = OP_START;
	coord_t               start_x = '0;
	coord_t               start_y = '0;
	logic [1:0]           axis_mode = MODE_LEAST;
	coord_t               wall_left = '0;
	coord_t               wall_top = '0;
	coord_t               wall_right = '0;
	coord_t               wall_bottom = '0;
	logic                 solid = 1'b0;
	logic                 last_wall = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	coord_t               box_x;
	coord_t               box_y;
	logic                 stopped_x;
	logic                 stopped_y;
	logic                 done_res;

	// tracked block state and box size
	coord_t               track_x = '0;
	coord_t               track_y = '0;
	logic [1:0]           track_mode = MODE_LEAST;
	logic                 hit_x = 1'b0;
	logic                 hit_y = 1'b0;
	logic [SIZE_BITS-1:0] box_w = BOX_WIDTH_RST;
	logic [SIZE_BITS-1:0] box_h = BOX_HEIGHT_RST;

	// stimulus and scoreboard
	in_word_t    pending_words[$];
	pos_word_t   expected_pos[$];
	in_word_t    on_bus;
	pos_word_t   want_pos;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          words_added = 0;
	int          results_seen = 0;
	int          hold_left = 0;
	int          error_count = 0;
	int unsigned cycle_count = 0;

	aabb_penetration_resolver dut (.*);

	always #5 clk = ~clk;

	function automatic coord_t sat_coord(longint v);
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		if (v < COORD_MIN)
			return coord_t'(COORD_MIN);
		return v[COORD_BITS-1:0];
	endfunction

	// expected position after one word; updates the tracked state
	function automatic pos_word_t resolve_word(in_word_t w);
		wide_t     size_w, size_h, pl, pr, pt, pb, wl, wr, wt, wb;
		wide_t     pen_l, pen_r, pen_t, pen_b, min_x, min_y;
		logic      push_x, push_y;
		pos_word_t res;
		push_x = 1'b0;
		push_y = 1'b0;
		res.done = 1'b0;
		if (w.op == OP_START) begin
			track_x = w.start_x;
			track_y = w.start_y;
			track_mode = w.mode;
			hit_x = 1'b0;
			hit_y = 1'b0;
		end else begin
			size_w = $signed({8'd0, box_w});
			size_h = $signed({8'd0, box_h});
			pl = WIDE_BITS'(track_x);
			pt = WIDE_BITS'(track_y);
			pr = pl + size_w;
			pb = pt + size_h;
			wl = WIDE_BITS'(w.left);
			wr = WIDE_BITS'(w.right);
			wt = WIDE_BITS'(w.top);
			wb = WIDE_BITS'(w.bottom);
			pen_l = pr - wl;
			pen_r = wr - pl;
			pen_t = pb - wt;
			pen_b = wb - pt;
			// strict overlap of a solid wall
			if (w.solid && pr > wl && pl < wr && pb > wt && pt < wb) begin
				min_x = (pen_l < pen_r) ? pen_l : pen_r;
				min_y = (pen_t < pen_b) ? pen_t : pen_b;
				case (track_mode)
					MODE_X: push_x = 1'b1;
					MODE_Y: push_y = 1'b1;
					default: begin
						// ties go vertical
						push_x = min_x < min_y;
						push_y = !push_x;
					end
				endcase
				if (push_x) begin
					track_x = (pen_l < pen_r) ? sat_coord(longint'(wl - size_w))
						: sat_coord(longint'(wr));
					hit_x = 1'b1;
				end
				if (push_y) begin
					track_y = (pen_t < pen_b) ? sat_coord(longint'(wt - size_h))
						: sat_coord(longint'(wb));
					hit_y = 1'b1;
				end
			end
			res.done = w.last;
		end
		res.x = track_x;
		res.y = track_y;
		res.stop_x = hit_x;
		res.stop_y = hit_y;
		return res;
	endfunction

	function automatic longint rand_between(longint lo, longint hi);
		return lo + longint'($urandom_range(32'(hi - lo)));
	endfunction

	function automatic coord_t rand_coord();
		return COORD_BITS'($urandom);
	endfunction

	// every field random, unused ones included
	function automatic in_word_t random_word();
		in_word_t w;
		w.op = 1'($urandom_range(1));
		w.start_x = rand_coord();
		w.start_y = rand_coord();
		w.mode = 2'($urandom_range(3));
		w.left = rand_coord();
		w.top = rand_coord();
		w.right = rand_coord();
		w.bottom = rand_coord();
		w.solid = 1'($urandom_range(1));
		w.last = 1'($urandom_range(1));
		return w;
	endfunction

	function automatic void add_word(in_word_t w);
		pending_words = {pending_words, w};
		words_added++;
	endfunction

	function automatic void add_start(longint x, longint y, logic [1:0] mode);
		in_word_t w;
		w = random_word();
		w.op = OP_START;
		w.start_x = sat_coord(x);
		w.start_y = sat_coord(y);
		w.mode = mode;
		add_word(w);
	endfunction

	function automatic void add_wall(longint l, longint t, longint r, longint b,
			logic is_solid, logic is_last);
		in_word_t w;
		w = random_word();
		w.op = OP_WALL;
		w.left = sat_coord(l);
		w.top = sat_coord(t);
		w.right = sat_coord(r);
		w.bottom = sat_coord(b);
		w.solid = is_solid;
		w.last = is_last;
		add_word(w);
	endfunction

	// start word plus a few walls around it; some noise and broken sequences
	function automatic void add_sequence();
		longint sx, sy, sw, sh, l, t, r, b, tmp;
		int     n, i;
		logic   is_last;
		if ($urandom_range(9) == 0) begin
			add_word(random_word());
			return;
		end
		sw = (box_w < 16'd8) ? 64'sd8 : longint'(box_w);
		sh = (box_h < 16'd8) ? 64'sd8 : longint'(box_h);
		if ($urandom_range(6) == 0)
			sx = $urandom_range(1) ? COORD_MAX - rand_between(0, 2 * sw)
				: COORD_MIN + rand_between(0, 2 * sw);
		else
			sx = rand_between(-(64'sd1 << 18), 64'sd1 << 18);
		if ($urandom_range(6) == 0)
			sy = $urandom_range(1) ? COORD_MAX - rand_between(0, 2 * sh)
				: COORD_MIN + rand_between(0, 2 * sh);
		else
			sy = rand_between(-(64'sd1 << 18), 64'sd1 << 18);
		add_start(sx, sy, ($urandom_range(15) == 0) ? MODE_SPARE : 2'($urandom_range(2)));
		n = $urandom_range(6, 1);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				// wall on the box itself: equal push both ways
				l = sx;
				t = sy;
				r = sx + longint'(box_w);
				b = sy + longint'(box_h);
			end else begin
				l = sx + rand_between(-2 * sw, sw);
				t = sy + rand_between(-2 * sh, sh);
				r = l + rand_between(1, 2 * sw);
				b = t + rand_between(1, 2 * sh);
			end
			if ($urandom_range(19) == 0) begin
				tmp = l;
				l = r;
				r = tmp;
			end
			if ($urandom_range(19) == 0) begin
				tmp = t;
				t = b;
				b = tmp;
			end
			is_last = (i == n - 1) ? ($urandom_range(15) != 0) : ($urandom_range(15) == 0);
			add_wall(l, t, r, b, $urandom_range(7) != 0, is_last);
		end
	endfunction

	// wait until every word is sent and every result is back
	task automatic drain_pending();
		while (pending_words.size() != 0 || in_valid || expected_pos.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_box_size(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_BOX_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_BOX_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		box_w = w;
		box_h = h;
		@(negedge clk);
	endtask

	// driver: predict on accept, then offer the next pending word
	always @(posedge clk) begin
		if (in_valid && in_ready)
			expected_pos = {expected_pos, resolve_word(on_bus)};
		if (!in_valid || in_ready) begin
			if (arst_n && pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				on_bus = pending_words.pop_front();
				op <= on_bus.op;
				start_x <= on_bus.start_x;
				start_y <= on_bus.start_y;
				axis_mode <= on_bus.mode;
				wall_left <= on_bus.left;
				wall_top <= on_bus.top;
				wall_right <= on_bus.right;
				wall_bottom <= on_bus.bottom;
				solid <= on_bus.solid;
				last_wall <= on_bus.last;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each result word against the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_pos.size() == 0) begin
				$error("result word with none expected: box_x %0d box_y %0d", box_x, box_y);
				error_count++;
			end else begin
				want_pos = expected_pos.pop_front();
				if (box_x !== want_pos.x) begin
					$error("box_x: expected %0d, got %0d", want_pos.x, box_x);
					error_count++;
				end
				if (box_y !== want_pos.y) begin
					$error("box_y: expected %0d, got %0d", want_pos.y, box_y);
					error_count++;
				end
				if (stopped_x !== want_pos.stop_x) begin
					$error("stopped_x: expected %0b, got %0b", want_pos.stop_x, stopped_x);
					error_count++;
				end
				if (stopped_y !== want_pos.stop_y) begin
					$error("stopped_y: expected %0b, got %0b", want_pos.stop_y, stopped_y);
					error_count++;
				end
				if (done_res !== want_pos.done) begin
					$error("done_res: expected %0b, got %0b", want_pos.done, done_res);
					error_count++;
				end
			end
			results_seen++;
			// long back-pressure now and then so the input side stalls
			if (results_seen % 400 == 200)
				hold_left = 80;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 22;
		recv_idle_pct = 45;

		// directed words, reset box size 512 x 768
		add_wall(100, -1000, 10000, 10000, 1'b1, 1'b0);
		add_wall(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
		add_start(0, 0, MODE_LEAST);
		add_wall(412, 668, 5000, 5000, 1'b1, 1'b0);
		add_start(0, 0, MODE_X);
		add_wall(0, 0, 512, 768, 1'b1, 1'b0);
		add_start(0, 0, MODE_Y);
		add_wall(0, 0, 512, 768, 1'b1, 1'b1);
		add_start(1000, 1000, MODE_LEAST);
		add_wall(1512, 1000, 2000, 2000, 1'b1, 1'b0);
		add_wall(1100, 1100, 1200, 1200, 1'b0, 1'b1);
		add_wall(1400, 1100, 1100, 1200, 1'b1, 1'b0);
		add_start(COORD_MIN, COORD_MIN, MODE_X);
		add_wall(COORD_MIN + 10, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
		add_start(COORD_MIN, COORD_MIN, MODE_Y);
		add_wall(COORD_MIN, COORD_MIN + 8, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
		add_start(COORD_MAX, COORD_MAX, MODE_SPARE);
		add_wall(524000, 524000, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
		add_start(0, 0, MODE_X);
		add_wall(400, 0, 5000, 768, 1'b1, 1'b0);
		add_wall(-5000, -5000, -50, 5000, 1'b1, 1'b1);
		add_start(-1, -1, MODE_LEAST);
		drain_pending();

		// random part, box size changed between chunks
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			if (chunk == 4) begin
				send_idle_pct = 45;
				recv_idle_pct = 22;
			end
			if (chunk == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (chunk)
				0: write_box_size(16'd0, 16'd0);
				1: write_box_size(16'hFFFF, 16'hFFFF);
				2: write_box_size(16'd1, 16'hFFFF);
				3: write_box_size(16'hFFFF, 16'd1);
				4: write_box_size(BOX_WIDTH_RST, BOX_HEIGHT_RST);
				default: write_box_size(SIZE_BITS'($urandom_range(2048, 16)),
					SIZE_BITS'($urandom_range(2048, 16)));
			endcase
			words_added = 0;
			while (words_added < CHUNK_WORDS)
				add_sequence();
			drain_pending();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
